@@ rtl/core/pot_pkg.sv @@
// Shared types and constants of the polygon overlap test.
// Used by pot_ctrl, pot_dp and polygon_overlap_test; no dependencies.
package pot_pkg;

  localparam int MIN_VERTICES = 3;

  // product-unit operations: edge cross signs (ABC, ABD, CDA, CDB), between dots (CAB, DAB, ACD, BCD), inside test
  localparam logic [3:0] OP_CROSS_ABC  = 4'd0;
  localparam logic [3:0] OP_CROSS_ABD  = 4'd1;
  localparam logic [3:0] OP_CROSS_CDA  = 4'd2;
  localparam logic [3:0] OP_CROSS_CDB  = 4'd3;
  localparam logic [3:0] OP_DOT_CAB    = 4'd4;
  localparam logic [3:0] OP_DOT_DAB    = 4'd5;
  localparam logic [3:0] OP_DOT_ACD    = 4'd6;
  localparam logic [3:0] OP_DOT_BCD    = 4'd7;
  localparam logic [3:0] OP_INSIDE     = 4'd8;

  typedef struct packed {
    logic       wr1;
    logic       wr2;
    logic       ld_a;
    logic       ld_b;
    logic       swap;
    logic       w1_from2;
    logic       eval;
    logic       clr_in;
    logic [3:0] op;
  } pot_cmd_t;

  typedef struct packed {
    logic meet;
    logic in_poly;
  } pot_sts_t;

endpackage

@@ rtl/core/polygon_overlap_test.sv @@
// Top level of the polygon overlap test: stream ports, controller and datapath.
// Depends on pot_pkg, pot_ctrl, pot_dp and pot_ram.
//
// Vertices are taken one beat per cycle while the block is loading. The beat of the
// second polygon that carries tlast starts the test; no input is taken until its
// result is in the output register. The test checks every edge pair, then each
// vertex of one polygon against the edges of the other, both ways, and ends early
// when an overlap is found. Every cross or dot product goes through the single
// shared two-multiplier product unit, in its difference, product and sum registers,
// and the vertices come from the registered reads of the two vertex stores. A result
// waits in the output register while the next polygons load.
module polygon_overlap_test import pot_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // vertex_x [31:0], vertex_y [63:32]
  input  logic        in_tuser,   // func
  input  logic        in_tlast,   // end_of_polygon
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // intersected, too_few_vertices, vertex_overflow, zeros
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(MAX_VERTICES);

  pot_cmd_t      cmd;
  pot_sts_t      sts;
  logic [AW-1:0] wr_addr, rd_addr1, rd_addr2;
  logic [2:0]    res;

  assign cfg_ready = 1'b1;
  assign out_tdata = {5'b0, res[2], res[1], res[0]};

  pot_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_second(in_tuser), .in_last(in_tlast),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res),
    .cmd(cmd), .sts(sts),
    .wr_addr(wr_addr), .rd_addr1(rd_addr1), .rd_addr2(rd_addr2)
  );

  pot_dp #(.MAX_VERTICES(MAX_VERTICES), .COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cmd(cmd), .sts(sts),
    .wr_addr(wr_addr), .rd_addr1(rd_addr1), .rd_addr2(rd_addr2),
    .in_x(in_tdata[31:0]), .in_y(in_tdata[63:32]),
    .cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data)
  );

endmodule

@@ rtl/core/pot_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pot_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/pot_dp.sv @@
// Datapath of the polygon overlap test: vertex stores, working points,
// shared product unit, sign evaluation. Depends on pot_pkg and pot_ram.
module pot_dp import pot_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_WIDTH  = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pot_cmd_t                        cmd,
  output pot_sts_t                        sts,
  input  logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
  input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr1,
  input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr2,
  input  logic [31:0]                     in_x,
  input  logic [31:0]                     in_y,
  input  logic                            cfg_we,
  input  logic [31:0]                     cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int PW = 2 * CW + 2;
  localparam int SW = 2 * CW + 3;
  localparam int VW = 2 * CW;

  logic [VW-1:0] wdata, rdata1, rdata2;
  logic [31:0]   tol_r;

  logic signed [CW-1:0] r1x, r1y, r2x, r2y;
  logic signed [CW-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r, dx_r, dy_r;
  logic signed [CW-1:0] ox, oy, ux, uy, vx, vy;
  logic                 is_dot;
  logic signed [DW-1:0] dp_r, dq_r, dr_r, ds_r;
  logic signed [PW-1:0] m1_r, m2_r;
  logic signed [SW-1:0] sum_r;
  logic [SW-1:0]        mag;
  logic                 neg, zero, sneg, spos, span, dypos, toggle;
  logic [1:0]           sg_r [8];
  logic                 in_r;

  assign wdata = {in_y[CW-1:0], in_x[CW-1:0]};

  pot_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_ram1 (
    .clk(clk), .we(cmd.wr1), .waddr(wr_addr), .wdata(wdata),
    .raddr(rd_addr1), .rdata(rdata1)
  );

  pot_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_ram2 (
    .clk(clk), .we(cmd.wr2), .waddr(wr_addr), .wdata(wdata),
    .raddr(rd_addr2), .rdata(rdata2)
  );

  assign r1x = signed'(rdata1[CW-1:0]);
  assign r1y = signed'(rdata1[VW-1:CW]);
  assign r2x = signed'(rdata2[CW-1:0]);
  assign r2y = signed'(rdata2[VW-1:CW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_we) begin
      tol_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_a) begin
      ax_r <= cmd.swap ? r2x : r1x;
      ay_r <= cmd.swap ? r2y : r1y;
      cx_r <= cmd.swap ? r1x : r2x;
      cy_r <= cmd.swap ? r1y : r2y;
    end
    if (cmd.ld_b) begin
      bx_r <= cmd.w1_from2 ? r2x : r1x;
      by_r <= cmd.w1_from2 ? r2y : r1y;
      dx_r <= r2x;
      dy_r <= r2y;
    end
  end

  always_comb begin
    is_dot = 1'b0;
    ox = ax_r; oy = ay_r; ux = bx_r; uy = by_r; vx = cx_r; vy = cy_r;
    unique case (cmd.op)
      OP_CROSS_ABC: begin
        ox = ax_r; oy = ay_r; ux = bx_r; uy = by_r; vx = cx_r; vy = cy_r;
      end
      OP_CROSS_ABD: begin
        ox = ax_r; oy = ay_r; ux = bx_r; uy = by_r; vx = dx_r; vy = dy_r;
      end
      OP_CROSS_CDA: begin
        ox = cx_r; oy = cy_r; ux = dx_r; uy = dy_r; vx = ax_r; vy = ay_r;
      end
      OP_CROSS_CDB: begin
        ox = cx_r; oy = cy_r; ux = dx_r; uy = dy_r; vx = bx_r; vy = by_r;
      end
      OP_DOT_CAB: begin
        is_dot = 1'b1;
        ox = cx_r; oy = cy_r; ux = ax_r; uy = ay_r; vx = bx_r; vy = by_r;
      end
      OP_DOT_DAB: begin
        is_dot = 1'b1;
        ox = dx_r; oy = dy_r; ux = ax_r; uy = ay_r; vx = bx_r; vy = by_r;
      end
      OP_DOT_ACD: begin
        is_dot = 1'b1;
        ox = ax_r; oy = ay_r; ux = cx_r; uy = cy_r; vx = dx_r; vy = dy_r;
      end
      OP_DOT_BCD: begin
        is_dot = 1'b1;
        ox = bx_r; oy = by_r; ux = cx_r; uy = cy_r; vx = dx_r; vy = dy_r;
      end
      OP_INSIDE: begin
        ox = bx_r; oy = by_r; ux = ax_r; uy = ay_r; vx = cx_r; vy = cy_r;
      end
      default: begin
        is_dot = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    dp_r  <= DW'(ux) - DW'(ox);
    dq_r  <= is_dot ? DW'(vx) - DW'(ox) : DW'(vy) - DW'(oy);
    dr_r  <= is_dot ? DW'(uy) - DW'(oy) : DW'(vx) - DW'(ox);
    ds_r  <= is_dot ? DW'(vy) - DW'(oy) : DW'(uy) - DW'(oy);
    m1_r  <= PW'(dp_r) * PW'(dq_r);
    m2_r  <= PW'(dr_r) * PW'(ds_r);
    sum_r <= is_dot ? SW'(m1_r) + SW'(m2_r) : SW'(m1_r) - SW'(m2_r);
  end

  assign neg  = sum_r[SW-1];
  assign mag  = neg ? SW'(-sum_r) : SW'(sum_r);
  assign zero = (cmd.op == OP_INSIDE) ? (sum_r == '0) : (mag <= SW'(tol_r));
  assign sneg = neg && !zero;
  assign spos = !neg && !zero;

  // pt in A, vi in B, vj in C
  assign span = ((by_r <= ay_r) && (ay_r < cy_r)) || ((cy_r <= ay_r) && (ay_r < by_r));
  assign dypos  = cy_r > by_r;
  assign toggle = span && (dypos ? sneg : spos);

  always_ff @(posedge clk) begin
    if (cmd.eval && !cmd.op[3]) begin
      sg_r[cmd.op[2:0]] <= {sneg, spos};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_r <= 1'b0;
    end else if (cmd.clr_in) begin
      in_r <= 1'b0;
    end else if (cmd.eval && cmd.op == OP_INSIDE && toggle) begin
      in_r <= !in_r;
    end
  end

  assign sts.meet =
      (((sg_r[0][1] && sg_r[1][0]) || (sg_r[0][0] && sg_r[1][1])) &&
       ((sg_r[2][1] && sg_r[3][0]) || (sg_r[2][0] && sg_r[3][1]))) ||
      (sg_r[0] == 2'b00 && !sg_r[4][0]) ||
      (sg_r[1] == 2'b00 && !sg_r[5][0]) ||
      (sg_r[2] == 2'b00 && !sg_r[6][0]) ||
      (sg_r[3] == 2'b00 && !sg_r[7][0]);
  assign sts.in_poly = in_r;

endmodule

@@ rtl/core/pot_ctrl.sv @@
// Controller of the polygon overlap test: vertex counts, loop indexes,
// sequencing of the product unit, result register. Depends on pot_pkg.
module pot_ctrl import pot_pkg::*; #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_second,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_res,
  output pot_cmd_t                        cmd,
  input  pot_sts_t                        sts,
  output logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
  output logic [$clog2(MAX_VERTICES)-1:0] rd_addr1,
  output logic [$clog2(MAX_VERTICES)-1:0] rd_addr2
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_CHECK  = 12'b000000000010,
    S_RD0    = 12'b000000000100,
    S_RD1    = 12'b000000001000,
    S_RD2    = 12'b000000010000,
    S_DIFF   = 12'b000000100000,
    S_MUL    = 12'b000001000000,
    S_SUM    = 12'b000010000000,
    S_EVAL   = 12'b000100000000,
    S_DECIDE = 12'b001000000000,
    S_FINISH = 12'b010000000000,
    S_SPARE  = 12'b100000000000
  } state_t;

  typedef enum logic [1:0] {
    PH_EDGE = 2'd0,
    PH_IN1  = 2'd1,
    PH_IN2  = 2'd2
  } phase_t;

  state_t          state_r, state_nxt;
  phase_t          ph_r, ph_nxt;
  logic [NW-1:0]   cnt1_r, cnt1_nxt, cnt2_r, cnt2_nxt;
  logic [AW-1:0]   i_r, i_nxt, j_r, j_nxt;
  logic [3:0]      op_r, op_nxt;
  logic            ovf_r, ovf_nxt, few_r, few_nxt, hit_r, hit_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [2:0]      res_r, res_nxt;
  logic            acc, full1, full2;
  logic            lasti1, lasti2, lastj1, lastj2;
  logic [AW-1:0]   ni1, nj1, nj2;

  assign acc   = in_valid && in_ready;
  assign full1 = cnt1_r == NW'(MAX_VERTICES);
  assign full2 = cnt2_r == NW'(MAX_VERTICES);

  assign lasti1 = NW'(i_r) == cnt1_r - 1'b1;
  assign lasti2 = NW'(i_r) == cnt2_r - 1'b1;
  assign lastj1 = NW'(j_r) == cnt1_r - 1'b1;
  assign lastj2 = NW'(j_r) == cnt2_r - 1'b1;
  assign ni1 = lasti1 ? '0 : i_r + 1'b1;
  assign nj1 = lastj1 ? '0 : j_r + 1'b1;
  assign nj2 = lastj2 ? '0 : j_r + 1'b1;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign wr_addr   = in_second ? cnt2_r[AW-1:0] : cnt1_r[AW-1:0];

  always_comb begin
    if (state_r == S_RD1) begin
      rd_addr1 = (ph_r == PH_IN2) ? nj1 : ni1;
      rd_addr2 = nj2;
    end else begin
      rd_addr1 = (ph_r == PH_IN2) ? j_r : i_r;
      rd_addr2 = (ph_r == PH_IN2) ? i_r : j_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    cnt1_nxt      = cnt1_r;
    cnt2_nxt      = cnt2_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    op_nxt        = op_r;
    ovf_nxt       = ovf_r;
    few_nxt       = few_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    cmd           = '0;
    cmd.op        = op_r;
    cmd.swap      = ph_r == PH_IN2;
    cmd.w1_from2  = ph_r == PH_IN1;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_second) begin
            if (full2) begin
              ovf_nxt = 1'b1;
            end else begin
              cmd.wr2  = 1'b1;
              cnt2_nxt = cnt2_r + 1'b1;
            end
            if (in_last) begin
              state_nxt = S_CHECK;
            end
          end else begin
            if (full1) begin
              ovf_nxt = 1'b1;
            end else begin
              cmd.wr1  = 1'b1;
              cnt1_nxt = cnt1_r + 1'b1;
            end
          end
        end
      end
      S_CHECK: begin
        few_nxt    = (cnt1_r < NW'(MIN_VERTICES)) || (cnt2_r < NW'(MIN_VERTICES));
        hit_nxt    = 1'b0;
        ph_nxt     = PH_EDGE;
        i_nxt      = '0;
        j_nxt      = '0;
        cmd.clr_in = 1'b1;
        state_nxt  = few_nxt ? S_FINISH : S_RD0;
      end
      S_RD0: begin
        op_nxt    = (ph_r == PH_EDGE) ? OP_CROSS_ABC : OP_INSIDE;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd.ld_a  = 1'b1;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        cmd.ld_b  = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_EVAL;
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (ph_r == PH_EDGE && op_r != OP_DOT_BCD) begin
          op_nxt    = op_r + 1'b1;
          state_nxt = S_DIFF;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_RD0;
        unique case (ph_r)
          PH_EDGE: begin
            if (sts.meet) begin
              hit_nxt   = 1'b1;
              state_nxt = S_FINISH;
            end else if (!lastj2) begin
              j_nxt = j_r + 1'b1;
            end else begin
              j_nxt = '0;
              if (!lasti1) begin
                i_nxt = i_r + 1'b1;
              end else begin
                i_nxt      = '0;
                ph_nxt     = PH_IN1;
                cmd.clr_in = 1'b1;
              end
            end
          end
          PH_IN1: begin
            if (!lastj2) begin
              j_nxt = j_r + 1'b1;
            end else if (sts.in_poly) begin
              hit_nxt   = 1'b1;
              state_nxt = S_FINISH;
            end else begin
              j_nxt      = '0;
              cmd.clr_in = 1'b1;
              if (!lasti1) begin
                i_nxt = i_r + 1'b1;
              end else begin
                i_nxt  = '0;
                ph_nxt = PH_IN2;
              end
            end
          end
          default: begin
            if (!lastj1) begin
              j_nxt = j_r + 1'b1;
            end else if (sts.in_poly) begin
              hit_nxt   = 1'b1;
              state_nxt = S_FINISH;
            end else begin
              j_nxt      = '0;
              cmd.clr_in = 1'b1;
              if (!lasti2) begin
                i_nxt = i_r + 1'b1;
              end else begin
                state_nxt = S_FINISH;
              end
            end
          end
        endcase
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          res_nxt       = {ovf_r, few_r, hit_r};
          cnt1_nxt      = '0;
          cnt2_nxt      = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= PH_EDGE;
      cnt1_r      <= '0;
      cnt2_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      cnt1_r      <= cnt1_nxt;
      cnt2_r      <= cnt2_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    op_r  <= op_nxt;
    few_r <= few_nxt;
    hit_r <= hit_nxt;
    res_r <= res_nxt;
  end

endmodule

@@ dv/polygon_overlap_test_tb.sv @@
// Testbench for polygon_overlap_test: streams polygon pairs, predicts each
// overlap verdict with a behavioral model and compares beat by beat.
// Depends on pot_pkg and the polygon_overlap_test RTL.
`timescale 1ns / 1ps

module polygon_overlap_test_tb;
  import pot_pkg::*;

  localparam int NV = 16;
  localparam int WATCHDOG = 200000;

  typedef struct packed {
    logic        poly2;
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
  } vtx_beat_t;

  typedef struct packed {
    logic hit;
    logic few;
    logic ovf;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  always #6 clk = ~clk;

  polygon_overlap_test u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  longint    poly_a [NV][2];
  longint    poly_b [NV][2];
  int        cnt_a, cnt_b;
  bit        ovf_seen;
  bit [31:0] tol;

  verdict_t  verdicts_due [$];
  verdict_t  last_verdict;
  int        errors, beats_sent, verdicts_seen, idle_cycles;
  int        send_idle_pct, recv_idle_pct;
  bit        timed_out;

  function automatic int tsign(logic signed [127:0] v);
    logic [127:0] m;
    m = v[127] ? -v : v;
    if (m <= {96'd0, tol}) return 0;
    return v[127] ? -1 : 1;
  endfunction

  function automatic logic signed [127:0] cross_of(longint ax, longint ay, longint bx,
      longint by, longint cx, longint cy);
    logic signed [127:0] p, q;
    p = 128'(bx - ax) * 128'(cy - ay);
    q = 128'(cx - ax) * 128'(by - ay);
    return p - q;
  endfunction

  function automatic int dot_sign(longint px, longint py, longint ax, longint ay,
      longint bx, longint by);
    logic signed [127:0] p, q;
    p = 128'(ax - px) * 128'(bx - px);
    q = 128'(ay - py) * 128'(by - py);
    return tsign(p + q);
  endfunction

  function automatic bit edges_touch(longint ax, longint ay, longint bx, longint by,
      longint cx, longint cy, longint dx, longint dy);
    int d1, d2, d3, d4;
    d1 = tsign(cross_of(ax, ay, bx, by, cx, cy));
    d2 = tsign(cross_of(ax, ay, bx, by, dx, dy));
    d3 = tsign(cross_of(cx, cy, dx, dy, ax, ay));
    d4 = tsign(cross_of(cx, cy, dx, dy, bx, by));
    if (d1 * d2 < 0 && d3 * d4 < 0) return 1;
    if (d1 == 0 && dot_sign(cx, cy, ax, ay, bx, by) <= 0) return 1;
    if (d2 == 0 && dot_sign(dx, dy, ax, ay, bx, by) <= 0) return 1;
    if (d3 == 0 && dot_sign(ax, ay, cx, cy, dx, dy) <= 0) return 1;
    if (d4 == 0 && dot_sign(bx, by, cx, cy, dx, dy) <= 0) return 1;
    return 0;
  endfunction

  function automatic bit point_in(bit in_b, int n, longint px, longint py);
    bit in;
    int j;
    longint ix, iy, jx, jy, dy;
    logic signed [127:0] lhs, rhs;
    in = 0;
    j = n - 1;
    for (int i = 0; i < n; i++) begin
      ix = in_b ? poly_b[i][0] : poly_a[i][0];
      iy = in_b ? poly_b[i][1] : poly_a[i][1];
      jx = in_b ? poly_b[j][0] : poly_a[j][0];
      jy = in_b ? poly_b[j][1] : poly_a[j][1];
      if ((iy <= py && py < jy) || (jy <= py && py < iy)) begin
        dy = jy - iy;
        lhs = 128'(px - ix) * 128'(dy);
        rhs = 128'(jx - ix) * 128'(py - iy);
        if (dy > 0 ? lhs < rhs : lhs > rhs) in = !in;
      end
      j = i;
    end
    return in;
  endfunction

  function automatic bit polygons_overlap();
    for (int i = 0; i < cnt_a; i++)
      for (int j = 0; j < cnt_b; j++)
        if (edges_touch(poly_a[i][0], poly_a[i][1],
            poly_a[(i + 1) % cnt_a][0], poly_a[(i + 1) % cnt_a][1],
            poly_b[j][0], poly_b[j][1],
            poly_b[(j + 1) % cnt_b][0], poly_b[(j + 1) % cnt_b][1]))
          return 1;
    for (int i = 0; i < cnt_a; i++)
      if (point_in(1, cnt_b, poly_a[i][0], poly_a[i][1])) return 1;
    for (int i = 0; i < cnt_b; i++)
      if (point_in(0, cnt_a, poly_b[i][0], poly_b[i][1])) return 1;
    return 0;
  endfunction

  // returns 1 and fills v when the beat closes a pair
  function automatic bit predict_verdict(vtx_beat_t b, output verdict_t v);
    v = '0;
    if (b.poly2 ? cnt_b < NV : cnt_a < NV) begin
      if (b.poly2) begin
        poly_b[cnt_b][0] = longint'($signed(b.x));
        poly_b[cnt_b][1] = longint'($signed(b.y));
        cnt_b++;
      end else begin
        poly_a[cnt_a][0] = longint'($signed(b.x));
        poly_a[cnt_a][1] = longint'($signed(b.y));
        cnt_a++;
      end
    end else begin
      ovf_seen = 1;
    end
    if (!(b.poly2 && b.last)) return 0;
    v.few = cnt_a < MIN_VERTICES || cnt_b < MIN_VERTICES;
    v.hit = v.few ? 1'b0 : polygons_overlap();
    v.ovf = ovf_seen;
    cnt_a = 0;
    cnt_b = 0;
    ovf_seen = 0;
    return 1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d (verdict %0d)", what, got, want,
             verdicts_seen);
  endtask

  task automatic send_beat(vtx_beat_t b);
    verdict_t v;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b.y, b.x};
    in_tuser  <= b.poly2;
    in_tlast  <= b.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    if (predict_verdict(b, v)) verdicts_due = {verdicts_due, v};
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (verdicts_due.size() != 0 && !timed_out) @(posedge clk);
    repeat (4000) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [31:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tol = value;
  endtask

  task automatic send_polygon(bit poly2, int n, longint cx, longint cy, longint r,
      bit close);
    vtx_beat_t b;
    for (int i = 0; i < n; i++) begin
      b.poly2 = poly2;
      b.x = 32'(cx + longint'($urandom_range(2 * r)) - r);
      b.y = 32'(cy + longint'($urandom_range(2 * r)) - r);
      b.last = (i == n - 1) && close;
      send_beat(b);
    end
  endtask

  task automatic send_random_pair();
    int sel, n1, n2;
    longint r;
    sel = $urandom_range(99);
    r = sel < 50 ? 64'd65536 * $urandom_range(1, 8) : 64'd1 << $urandom_range(4, 30);
    n1 = sel < 85 ? $urandom_range(3, 6) : $urandom_range(0, 18);
    n2 = sel < 85 ? $urandom_range(3, 6) : $urandom_range(1, 18);
    send_polygon(0, n1, 0, 0, r, 1'($urandom_range(1)));
    send_polygon(1, n2, longint'($urandom_range(4 * r)) - 2 * r,
                 longint'($urandom_range(4 * r)) - 2 * r, r, 1);
  endtask

  // receiver, checker and watchdog
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready || out_tvalid && out_tready || cfg_valid && cfg_ready)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_tvalid && out_tready) begin
        verdicts_seen++;
        last_verdict = {out_tdata[0], out_tdata[1], out_tdata[2]};
        if (verdicts_due.size() == 0) begin
          report_mismatch("unexpected verdict", out_tdata, -1);
        end else begin
          want = verdicts_due.pop_front();
          if (out_tdata[0] !== want.hit) report_mismatch("intersected", out_tdata[0], want.hit);
          if (out_tdata[1] !== want.few)
            report_mismatch("too_few_vertices", out_tdata[1], want.few);
          if (out_tdata[2] !== want.ovf)
            report_mismatch("vertex_overflow", out_tdata[2], want.ovf);
          if (out_tdata[7:3] !== 5'd0) report_mismatch("padding", out_tdata[7:3], 0);
        end
      end
      out_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
      if (idle_cycles >= WATCHDOG && !timed_out) begin
        timed_out = 1;
        $display("TIMEOUT: no beat for %0d cycles", WATCHDOG);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // directed rows: {poly2, x, y, last}; unit square 0..1 and friends
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] TWO = 32'h0002_0000;
  localparam logic [31:0] HALF = 32'h0000_8000;
  localparam logic [31:0] MAXC = 32'h7fff_ffff;
  localparam logic [31:0] MINC = 32'h8000_0000;

  vtx_beat_t directed_rows [] = '{
    // first polygon too small, second triangle
    '{1'b0, 32'd0, 32'd0, 1'b1},
    '{1'b1, 32'd0, 32'd0, 1'b0}, '{1'b1, ONE, 32'd0, 1'b0}, '{1'b1, ONE, ONE, 1'b1},
    // extreme triangle vs small triangle beyond its long edge, end mark on first polygon mid-run
    '{1'b0, MINC, MINC, 1'b0}, '{1'b0, MAXC, MINC, 1'b1}, '{1'b0, MINC, MAXC, 1'b0},
    '{1'b1, 32'd0, 32'd0, 1'b0}, '{1'b1, HALF, 32'd0, 1'b0}, '{1'b1, 32'd0, HALF, 1'b1},
    // square vs touching triangle (shared corner) with a flat edge
    '{1'b0, 32'd0, 32'd0, 1'b0}, '{1'b0, ONE, 32'd0, 1'b0}, '{1'b0, ONE, ONE, 1'b0},
    '{1'b0, 32'd0, ONE, 1'b0},
    '{1'b1, ONE, ONE, 1'b0}, '{1'b1, TWO, ONE, 1'b0}, '{1'b1, TWO, TWO, 1'b1},
    // disjoint triangles, all-ones coordinates
    '{1'b0, 32'hffff_ffff, 32'hffff_ffff, 1'b0}, '{1'b0, 32'hffff_0000, 32'd0, 1'b0},
    '{1'b0, 32'd0, 32'hffff_0000, 1'b1},
    '{1'b1, TWO, TWO, 1'b0}, '{1'b1, 32'h0003_0000, TWO, 1'b0},
    '{1'b1, TWO, 32'h0003_0000, 1'b1}
  };
  verdict_t directed_verdicts [] = '{'{1'b0, 1'b1, 1'b0}};

  initial begin
    vtx_beat_t b;
    logic [31:0] tols [4];
    tols = '{32'd0, 32'hffff_ffff, 32'h0000_1000, 32'd0};
    errors = 0; beats_sent = 0; verdicts_seen = 0; idle_cycles = 0;
    cnt_a = 0; cnt_b = 0; ovf_seen = 0; tol = '0; timed_out = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i]);
      if (i == 3) begin
        wait_drained();
        if (verdicts_seen != 1) report_mismatch("first verdict count", verdicts_seen, 1);
        if (last_verdict !== directed_verdicts[0])
          report_mismatch("first verdict", int'(last_verdict), int'(directed_verdicts[0]));
      end
    end
    // overflow: 18 vertices each, end mark on a dropped vertex
    send_polygon(0, 18, 0, 0, 65536, 0);
    send_polygon(1, 18, 0, 0, 65536, 1);

    for (int phase = 0; phase < 4; phase++) begin
      write_tolerance(tols[phase]);
      send_idle_pct = phase == 0 ? 16 : phase == 1 ? 74 : 0;
      recv_idle_pct = phase == 0 ? 74 : phase == 1 ? 16 : 0;
      while (beats_sent < 400 * (phase + 1) + 50 && !timed_out) begin
        send_random_pair();
        if ($urandom_range(19) == 0) wait_drained();
      end
    end
    wait_drained();

    $display("Covered %0d vertex beats and %0d verdicts over four tolerance settings,",
             beats_sent, verdicts_seen);
    $display("including short polygons, store overflow and both idle patterns.");
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d verdicts outstanding", errors, verdicts_due.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
